// ===== design/hce_pkg.sv =====
// Package for the Hill cipher encryption unit.
// Holds the sizes, character codes, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package hce_pkg;

  localparam int MaxKey    = 7;
  localparam int LetterW   = 5;
  localparam int SizeW     = 3;
  localparam int SumW      = 13;
  localparam int RecipW    = 12;
  localparam int RecipShift = 16;

  localparam logic [LetterW-1:0] PadValue = 5'd23;
  localparam logic [4:0]         Alpha    = 5'd26;
  localparam logic [RecipW-1:0]  RecipAlpha = 12'd2521;

  localparam logic [7:0] LowerA = 8'd97;
  localparam logic [7:0] LowerZ = 8'd122;
  localparam logic [7:0] UpperA = 8'd65;
  localparam logic [7:0] UpperZ = 8'd90;

  localparam logic [SizeW-1:0] CfgKeySize = 3'd0;
  localparam logic [SizeW-1:0] KeySizeRst = 3'd2;

  typedef enum logic [1:0] {
    ClsLower,
    ClsUpper,
    ClsOther
  } byte_cls_e;

  typedef logic [MaxKey-1:0][LetterW-1:0] row_t;
  typedef row_t [MaxKey-1:0]              key_mat_t;

  typedef struct packed {
    row_t             letters;
    logic [SizeW-1:0] size;
  } blk_t;

endpackage

// ===== design/hill_cipher_encrypt_unit.sv =====
// Hill cipher encryption unit: one text byte per cycle while the block queue has room.
// A closing byte queues its block; its letters then pass the sum and output registers.
// The back end emits one letter per cycle while out_ready_i is high, key_size letters per block (one for key_size 0).
// Reset clears the fill count, queue, pipeline valids, key rows and sets key_size to 2.
// Uses hce_pkg, hce_front, hce_queue and hce_back.
`timescale 1ns / 1ps

module hill_cipher_encrypt_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hce_pkg::SizeW-1:0] cfg_index_i,
  input  logic [34:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                text_byte_i,
  input  logic                      end_of_text_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [6:0]                cipher_letter_o,
  output logic                      block_end_o
);
  import hce_pkg::*;

  logic [SizeW-1:0] key_size_q;
  logic [SizeW-1:0] size_act;
  key_mat_t         key_q;
  logic             cfg_we;
  logic             push;
  blk_t             blk;
  logic             full;
  logic             head_valid;
  blk_t             head;
  logic             pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign size_act    = (key_size_q == '0) ? 3'd1 : key_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= KeySizeRst;
      key_q      <= '0;
    end else if (cfg_we) begin
      if (cfg_index_i == CfgKeySize) begin
        key_size_q <= cfg_data_i[SizeW-1:0];
      end
      for (int r = 0; r < MaxKey; r++) begin
        if (cfg_index_i == SizeW'(r + 1)) begin
          key_q[r] <= cfg_data_i;
        end
      end
    end
  end

  hce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .size_i        (size_act),
    .full_i        (full),
    .push_o        (push),
    .blk_o         (blk)
  );

  hce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .blk_i   (blk),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head)
  );

  hce_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .key_i           (key_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cipher_letter_o (cipher_letter_o),
    .block_end_o     (block_end_o)
  );

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cipher_letter_o >= 7'd97 && cipher_letter_o <= 7'd122))
    else $error("cipher letter out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("block pushed into full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== design/hce_front.sv =====
// Front end: classifies text bytes, collects letters and closes blocks.
// Uses hce_pkg; feeds the block queue.
`timescale 1ns / 1ps

module hce_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                text_byte_i,
  input  logic                      end_of_text_i,
  input  logic [hce_pkg::SizeW-1:0] size_i,
  input  logic                      full_i,
  output logic                      push_o,
  output hce_pkg::blk_t             blk_o
);
  import hce_pkg::*;

  logic [SizeW-1:0]   fill_q, fill_d;
  row_t               letters_q;
  byte_cls_e          cls;
  logic [LetterW-1:0] val;
  logic               accept;
  logic               is_letter;
  logic               is_eot;
  logic [SizeW-1:0]   fill_w;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (text_byte_i >= LowerA && text_byte_i <= LowerZ) begin
      cls = ClsLower;
    end else if (text_byte_i >= UpperA && text_byte_i <= UpperZ) begin
      cls = ClsUpper;
    end else begin
      cls = ClsOther;
    end
  end

  always_comb begin
    unique case (cls)
      ClsLower: val = LetterW'(text_byte_i - LowerA);
      ClsUpper: val = LetterW'(text_byte_i - UpperA);
      default:  val = '0;
    endcase
  end

  assign is_eot    = accept && end_of_text_i;
  assign is_letter = accept && !end_of_text_i && (cls != ClsOther);
  assign fill_w    = (fill_q < SizeW'(MaxKey)) ? fill_q + 3'd1 : fill_q;

  always_comb begin
    push_o = 1'b0;
    if (is_letter) begin
      push_o = (fill_w >= size_i);
    end else if (is_eot) begin
      push_o = (fill_q != '0);
    end
  end

  always_comb begin
    for (int k = 0; k < MaxKey; k++) begin
      if (is_letter && fill_q == SizeW'(k)) begin
        blk_o.letters[k] = val;
      end else if (is_eot && SizeW'(k) >= fill_q) begin
        blk_o.letters[k] = PadValue;
      end else begin
        blk_o.letters[k] = letters_q[k];
      end
    end
    blk_o.size = size_i;
  end

  always_comb begin
    fill_d = fill_q;
    if (push_o) begin
      fill_d = '0;
    end else if (is_letter) begin
      fill_d = fill_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxKey; k++) begin
      if (is_letter && fill_q == SizeW'(k)) begin
        letters_q[k] <= val;
      end
    end
  end

endmodule

// ===== design/hce_queue.sv =====
// Two-entry block queue between front end and back end.
// Uses hce_pkg for the block type.
`timescale 1ns / 1ps

module hce_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hce_pkg::blk_t blk_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output hce_pkg::blk_t head_o
);
  import hce_pkg::*;

  blk_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= blk_i;
    end
  end

endmodule

// ===== design/hce_back.sv =====
// Back end: one key row per cycle unless the output stalls, dot product then mod 26 reduction.
// Uses hce_pkg; drains the block queue and drives the result port.
`timescale 1ns / 1ps

module hce_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  hce_pkg::blk_t    head_i,
  output logic             pop_o,
  input  hce_pkg::key_mat_t key_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [6:0]       cipher_letter_o,
  output logic             block_end_o
);
  import hce_pkg::*;

  logic [SizeW-1:0]           row_q, row_d;
  logic                       a_valid_q;
  logic [SumW-1:0]            sum_q, sum_d;
  logic                       a_last_q;
  logic                       out_valid_q;
  logic [LetterW-1:0]         letter_q;
  logic                       last_q;
  logic                       out_load;
  logic                       a_load;
  logic                       row_last;
  row_t                       key_row;
  logic [SumW+RecipW-1:0]     quot_full;
  logic [7:0]                 quot;
  logic [SumW-1:0]            rem_full;
  logic [LetterW-1:0]         rem;

  assign out_load = a_valid_q && (!out_valid_q || out_ready_i);
  assign a_load   = head_valid_i && (!a_valid_q || out_load);
  assign row_last = (row_q == head_i.size - 3'd1);
  assign pop_o    = a_load && row_last;
  assign key_row  = key_i[row_q];

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < MaxKey; j++) begin
      if (SizeW'(j) < head_i.size) begin
        sum_d = sum_d + SumW'(key_row[j]) * SumW'(head_i.letters[j]);
      end
    end
  end

  always_comb begin
    row_d = row_q;
    if (a_load) begin
      row_d = row_last ? '0 : row_q + 3'd1;
    end
  end

  always_comb begin
    quot_full = (SumW+RecipW)'(sum_q) * (SumW+RecipW)'(RecipAlpha);
    quot      = 8'(quot_full >> RecipShift);
    rem_full  = sum_q - SumW'(quot) * SumW'(Alpha);
    if (rem_full >= SumW'(Alpha)) begin
      rem = LetterW'(rem_full - SumW'(Alpha));
    end else begin
      rem = LetterW'(rem_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      if (a_load) begin
        a_valid_q <= 1'b1;
      end else if (out_load) begin
        a_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      sum_q    <= sum_d;
      a_last_q <= row_last;
    end
    if (out_load) begin
      letter_q <= rem;
      last_q   <= a_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_letter_o = 7'(LowerA) + {2'b00, letter_q};
  assign block_end_o     = last_q;

endmodule
